>>> hdl/ssan_pkg.sv
// ---------------------------------------------------------------------------
// ssan_pkg: shared types and constants of the subtitle text sanitizer
// Character codes, result kinds, the operation record passed from the
// front end to the back end, and the sizes derived from the bounds.
// ---------------------------------------------------------------------------
package ssan_pkg;

  // Bounds
  localparam int MAX_PENDING_BREAKS = 16;
  localparam int MAX_RESULTS        = 56;
  localparam int HDR_LEN            = 20;
  localparam int SLEN_W             = 17;
  localparam int FIFO_DEPTH         = 4;

  localparam int PEND_W     = $clog2(MAX_PENDING_BREAKS + 1);
  localparam int HDR_IDX_W  = $clog2(HDR_LEN);
  localparam int RES_W      = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h4E;

  // Result kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Operation classes handed to the back end
  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_BREAK = 2'd1,
    OP_END   = 2'd2
  } op_code_t;

  typedef struct packed {
    op_code_t   op;
    logic [7:0] ch;
    logic       last;   // final operation caused by its input byte
  } op_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       overflow;
  } result_t;

endpackage

>>> hdl/ssan_chan_if.sv
// ---------------------------------------------------------------------------
// ssan channel interfaces
// Valid/ready channels for raw sample bytes and for sanitized results.
// ---------------------------------------------------------------------------
interface ssan_in_if import ssan_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [7:0]        byte_value;
  logic [SLEN_W-1:0] sample_length;
  logic              is_final;

  modport source (output valid, byte_value, sample_length, is_final, input ready);
  modport sink   (input valid, byte_value, sample_length, is_final, output ready);
endinterface

interface ssan_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       overflow;
  logic       run_last;

  modport source (output valid, out_byte, kind, overflow, run_last, input ready);
  modport sink   (input valid, out_byte, kind, overflow, run_last, output ready);
endinterface

>>> hdl/ssan_front.sv
// ---------------------------------------------------------------------------
// ssan_front: byte classifier
// Tracks the position in the sample, decides the length prefix, applies NUL,
// CR, tag and brace filtering and turns each byte into zero to three
// operations (char, break, end), handed out one per cycle when not stalled.
// ---------------------------------------------------------------------------
module ssan_front import ssan_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  ssan_in_if.sink sample,
  output logic    op_valid,
  input  logic    op_ready,
  output op_t     op
);

  // Position in the sample: first byte, second byte, rest of the sample
  typedef enum logic [2:0] {
    POS_FIRST  = 3'b001,
    POS_SECOND = 3'b010,
    POS_BODY   = 3'b100
  } pos_t;

  typedef struct packed {
    logic     keep;
    op_code_t op;
    logic     tag;
    logic     stp;
  } take_t;

  // One byte through the text filter
  function automatic take_t take_byte(input logic [7:0] c, input logic tag,
                                      input logic stp);
    take_t t;
    t.keep = 1'b0;
    t.op   = OP_CHAR;
    t.tag  = tag;
    t.stp  = stp;
    if (!stp) begin
      case (c)
        CH_NUL: t.stp = 1'b1;
        CH_CR:  t.keep = 1'b0;
        CH_LF: begin
          t.keep = 1'b1;
          t.op   = OP_BREAK;
        end
        CH_LT:  t.tag = 1'b1;
        CH_GT:  t.tag = 1'b0;
        default: t.keep = !tag && (c != CH_LBRACE) && (c != CH_RBRACE);
      endcase
    end
    return t;
  endfunction

  pos_t        pos;
  pos_t        pos_next;
  logic [7:0]  held;
  logic        in_tag;
  logic        stopped;
  logic        tag_next;
  logic        stp_next;
  op_t         exp_q [3];
  logic [1:0]  exp_cnt;

  logic        accept;
  logic        push;
  logic [15:0] plen;
  logic        prefix_ok;
  logic [7:0]  first_src;
  take_t       t0;
  take_t       t1;
  op_t         cand [3];
  logic [2:0]  cand_v;
  op_t         list [3];
  logic [1:0]  list_n;

  // Handshakes
  assign op_valid     = (exp_cnt != 2'd0);
  assign op           = exp_q[0];
  assign push         = op_valid && op_ready;
  assign sample.ready = (exp_cnt == 2'd0) || ((exp_cnt == 2'd1) && op_ready);
  assign accept       = sample.valid && sample.ready;

  // Classification and operation list
  always_comb begin
    plen      = {held, sample.byte_value};
    prefix_ok = (plen != 16'd0) &&
                (({2'b00, plen} + 18'd2) <= {1'b0, sample.sample_length});
    first_src = (pos == POS_SECOND) ? held : sample.byte_value;
    t0        = take_byte(first_src, in_tag, stopped);
    t1        = take_byte(sample.byte_value, t0.tag, t0.stp);

    cand[0] = '{op: t0.op, ch: first_src, last: 1'b0};
    cand[1] = '{op: t1.op, ch: sample.byte_value, last: 1'b0};
    cand[2] = '{op: OP_END, ch: 8'h00, last: 1'b0};
    cand_v  = 3'b000;
    tag_next = in_tag;
    stp_next = stopped;

    unique case (pos)
      POS_FIRST: begin
        cand_v[0] = sample.is_final && t0.keep;
      end
      POS_SECOND: begin
        cand_v[0] = !prefix_ok && t0.keep;
        cand_v[1] = !prefix_ok && t1.keep;
        if (!prefix_ok) begin
          tag_next = t1.tag;
          stp_next = t1.stp;
        end
      end
      default: begin
        cand_v[0] = t0.keep;
        tag_next  = t0.tag;
        stp_next  = t0.stp;
      end
    endcase
    cand_v[2] = sample.is_final;

    if (sample.is_final) begin
      tag_next = 1'b0;
      stp_next = 1'b0;
      pos_next = POS_FIRST;
    end else begin
      pos_next = (pos == POS_FIRST) ? POS_SECOND : POS_BODY;
    end

    // pack kept operations to the front, flag the last one
    list   = cand;
    list_n = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (cand_v[i]) begin
        list[list_n] = cand[i];
        list_n       = list_n + 2'd1;
      end
    end
    if (list_n != 2'd0) begin
      list[list_n - 2'd1].last = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= POS_FIRST;
      in_tag  <= 1'b0;
      stopped <= 1'b0;
      exp_cnt <= 2'd0;
    end else if (accept) begin
      pos     <= pos_next;
      in_tag  <= tag_next;
      stopped <= stp_next;
      exp_cnt <= list_n;
    end else if (push) begin
      exp_cnt <= exp_cnt - 2'd1;
    end
  end

  // Expansion slots and held first byte
  always_ff @(posedge clk) begin
    if (accept) begin
      exp_q <= list;
      if (pos == POS_FIRST) begin
        held <= sample.byte_value;
      end
    end else if (push) begin
      exp_q[0] <= exp_q[1];
      exp_q[1] <= exp_q[2];
    end
  end

  // A final byte always returns the classifier to the start of a sample
  a_final_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && sample.is_final |=> (pos == POS_FIRST) && !in_tag && !stopped)
    else $error("classifier state not cleared after final byte");

endmodule

>>> hdl/ssan_fifo.sv
// ---------------------------------------------------------------------------
// ssan_fifo: operation queue
// Small first-word-fall-through queue between the classifier and the
// expander so that each side can stall on its own.
// ---------------------------------------------------------------------------
module ssan_fifo import ssan_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  op_t  wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output op_t  rd_data
);

  op_t                   slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr;
  logic [FIFO_PTR_W-1:0] rptr;
  logic [FIFO_CNT_W-1:0] cnt;
  logic                  wr;
  logic                  rd;

  assign wr_ready = (cnt != FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = slots[rptr];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_data;
    end
  end

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    wr && !rd |=> cnt == $past(cnt) + 1'b1)
    else $error("queue fill count lost a write");

endmodule

>>> hdl/ssan_back.sv
// ---------------------------------------------------------------------------
// ssan_back: operation expander
// Carries out queued operations: sends the dialogue header, holds trailing
// breaks and a trailing backslash, expands them when later text arrives and
// emits one result per cycle when not stalled. A staging slot marks the last
// result of each input byte before it enters the output register.
// ---------------------------------------------------------------------------
module ssan_back import ssan_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_ready,
  input  op_t         op,
  ssan_out_if.source  dialogue
);

  localparam logic [HDR_LEN*8-1:0] HDR_TEXT = "0,0,Default,,0,0,0,,";

  // Working state
  logic                 hs;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [PEND_W-1:0]    pend;
  logic                 half;
  logic                 hb;
  logic                 ovf;
  logic [RES_W-1:0]     res_cnt;

  logic                 hs_next;
  logic [HDR_IDX_W-1:0] hdr_idx_next;
  logic [PEND_W-1:0]    pend_next;
  logic                 half_next;
  logic                 hb_next;
  logic                 ovf_next;

  // Staging slot and output register
  logic    stg_valid;
  logic    stg_final;
  result_t stg;
  logic    ov;
  result_t odata;
  logic    orl;

  logic    out_free;
  logic    go;
  logic    is_bs;
  logic    is_n;
  logic    wants_flush;
  logic    flushing;
  logic    comp_text;
  logic    need_text;
  logic    emit;
  logic    pop;
  logic    last_pop;
  logic    r_gen;
  logic    pend_room;
  logic    stg_move;
  logic    move_last;
  result_t r;

  assign out_free = !ov || dialogue.ready;
  assign go       = op_valid && (!stg_valid || out_free);

  // Next step of the head operation
  always_comb begin
    is_bs     = (op.ch == CH_BSLASH);
    is_n      = (op.ch == CH_N);
    pend_room = (pend < PEND_W'(MAX_PENDING_BREAKS));

    unique case (op.op) inside
      OP_CHAR:          wants_flush = is_n ? !hb : (is_bs ? hb : 1'b1);
      OP_BREAK, OP_END: wants_flush = hb;
      default:          wants_flush = 1'b0;
    endcase
    flushing  = wants_flush && ((pend != '0) || hb);
    comp_text = (op.op == OP_CHAR) && !is_bs && !(is_n && hb);
    need_text = flushing || comp_text;

    hs_next      = hs;
    hdr_idx_next = hdr_idx;
    pend_next    = pend;
    half_next    = half;
    hb_next      = hb;
    ovf_next     = ovf;
    emit         = 1'b0;
    pop          = 1'b0;
    r            = '{out_byte: 8'h00, kind: KIND_TEXT, overflow: 1'b0};

    if (need_text && !hs) begin
      // header goes ahead of the first text byte
      emit       = 1'b1;
      r.out_byte = HDR_TEXT[8 * (HDR_LEN - 1 - int'(hdr_idx)) +: 8];
      if (hdr_idx == HDR_IDX_W'(HDR_LEN - 1)) begin
        hs_next      = 1'b1;
        hdr_idx_next = '0;
      end else begin
        hdr_idx_next = hdr_idx + 1'b1;
      end
    end else if (flushing) begin
      // held breaks first, then the held backslash
      emit = 1'b1;
      if (pend != '0) begin
        if (half) begin
          r.out_byte = CH_N;
          half_next  = 1'b0;
          pend_next  = pend - 1'b1;
        end else begin
          r.out_byte = CH_BSLASH;
          half_next  = 1'b1;
        end
      end else begin
        r.out_byte = CH_BSLASH;
        hb_next    = 1'b0;
      end
    end else begin
      pop = 1'b1;
      unique case (op.op)
        OP_CHAR: begin
          if (is_n && hb) begin
            hb_next = 1'b0;
            if (pend_room) pend_next = pend + 1'b1;
            else           ovf_next  = 1'b1;
          end else if (is_bs) begin
            hb_next = 1'b1;
          end else begin
            emit       = 1'b1;
            r.out_byte = op.ch;
          end
        end
        OP_BREAK: begin
          if (pend_room) pend_next = pend + 1'b1;
          else           ovf_next  = 1'b1;
        end
        OP_END: begin
          emit         = 1'b1;
          r.kind       = hs ? KIND_END : KIND_EMPTY;
          r.overflow   = ovf;
          hs_next      = 1'b0;
          hdr_idx_next = '0;
          pend_next    = '0;
          half_next    = 1'b0;
          hb_next      = 1'b0;
          ovf_next     = 1'b0;
        end
        default: hb_next = hb;
      endcase
    end

    last_pop  = pop && op.last;
    r_gen     = emit && (res_cnt != RES_W'(MAX_RESULTS));
    stg_move  = stg_valid && out_free && (stg_final || (go && (r_gen || last_pop)));
    move_last = stg_final || (go && last_pop && !r_gen);
  end

  assign op_ready = go && pop;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hs        <= 1'b0;
      hdr_idx   <= '0;
      pend      <= '0;
      half      <= 1'b0;
      hb        <= 1'b0;
      ovf       <= 1'b0;
      res_cnt   <= '0;
      stg_valid <= 1'b0;
      stg_final <= 1'b0;
      ov        <= 1'b0;
    end else begin
      if (go) begin
        hs      <= hs_next;
        hdr_idx <= hdr_idx_next;
        pend    <= pend_next;
        half    <= half_next;
        hb      <= hb_next;
        ovf     <= ovf_next;
        if (last_pop)   res_cnt <= '0;
        else if (r_gen) res_cnt <= res_cnt + 1'b1;
      end
      if (go && r_gen) begin
        stg_valid <= 1'b1;
        stg_final <= last_pop;
      end else if (stg_move) begin
        stg_valid <= 1'b0;
        stg_final <= 1'b0;
      end
      if (stg_move)            ov <= 1'b1;
      else if (dialogue.ready) ov <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (go && r_gen) begin
      stg <= r;
    end
    if (stg_move) begin
      odata <= stg;
      orl   <= move_last;
    end
  end

  assign dialogue.valid    = ov;
  assign dialogue.out_byte = odata.out_byte;
  assign dialogue.kind     = odata.kind;
  assign dialogue.overflow = odata.overflow;
  assign dialogue.run_last = orl;

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= PEND_W'(MAX_PENDING_BREAKS))
    else $error("pending break count above bound");

  a_half_pair: assert property (@(posedge clk) disable iff (rst)
    half |-> pend != '0)
    else $error("half-sent break with no pending break");

  a_final_staged: assert property (@(posedge clk) disable iff (rst)
    stg_final |-> stg_valid)
    else $error("last-result mark on empty staging slot");

endmodule

>>> hdl/subtitle_text_sample_sanitizer.sv
// ---------------------------------------------------------------------------
// subtitle_text_sample_sanitizer: text subtitle sample cleanup
// Throughput: one byte per cycle for plain text when the output is not stalled;
//   a final byte that keeps its character, an unprefixed second byte keeping
//   both or a two-byte sample holds the input until all its operations queue.
// Results leave one per cycle while accepted; header bytes, expanded breaks
//   (two bytes) and a held backslash each go out as one result per byte.
// Path: a byte's lone result passes the classifier slot, the operation queue,
//   the staging slot and the output register once the header is out.
// Reset: synchronous, clears all control state; no clearing pass needed.
// ---------------------------------------------------------------------------
module subtitle_text_sample_sanitizer import ssan_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ssan_in_if.sink     sample,
  ssan_out_if.source  dialogue
);

  logic f_valid;
  logic f_ready;
  op_t  f_op;
  logic b_valid;
  logic b_ready;
  op_t  b_op;

  // Classifier
  ssan_front u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  // Decoupling queue
  ssan_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_op),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_op)
  );

  // Expander
  ssan_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (b_valid),
    .op_ready (b_ready),
    .op       (b_op),
    .dialogue (dialogue)
  );

endmodule
